@@ hdl/wsfe_pkg.sv @@
package wsfe_pkg;

  // Lane count and pipeline depth
  localparam int WHEEL_COUNT = 4;
  localparam int LANE_LAT    = 62;
  localparam int OUT_LAT     = LANE_LAT + 1;

  localparam logic [15:0] SLIP_ONE = 16'd32768;
  localparam logic [19:0] U_MAX    = 20'd524288;
  localparam logic [17:0] E_Q16    = 18'd178145;

  typedef struct packed {
    logic [15:0]        radius;
    logic [15:0]        brk;
    logic [15:0]        coul;
    logic [15:0]        bslip;
    logic signed [15:0] visc;
    logic signed [15:0] bias;
    logic [15:0]        min_mu;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_RADIUS = 3'd0,
    REG_BRK    = 3'd1,
    REG_COUL   = 3'd2,
    REG_BSLIP  = 3'd3,
    REG_VISC   = 3'd4,
    REG_BIAS   = 3'd5,
    REG_MIN_MU = 3'd6
  } cfg_idx_t;

  // e^-k in Q.16 for the integer part
  function automatic logic [16:0] exp_int_rom(input logic [3:0] k);
    logic [16:0] v;
    case (k)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd24109;
      4'd2:    v = 17'd8869;
      4'd3:    v = 17'd3263;
      4'd4:    v = 17'd1200;
      4'd5:    v = 17'd442;
      4'd6:    v = 17'd162;
      4'd7:    v = 17'd60;
      4'd8:    v = 17'd22;
      4'd9:    v = 17'd8;
      4'd10:   v = 17'd3;
      4'd11:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // e^-(j/8) in Q.16 for the fractional part
  function automatic logic [16:0] exp_frac_rom(input logic [3:0] j);
    logic [16:0] v;
    case (j)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd57835;
      4'd2:    v = 17'd51039;
      4'd3:    v = 17'd45042;
      4'd4:    v = 17'd39750;
      4'd5:    v = 17'd35079;
      4'd6:    v = 17'd30957;
      4'd7:    v = 17'd27319;
      4'd8:    v = 17'd24109;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/wsfe_div.sv @@
module wsfe_div #(
  parameter int RW = 16,
  parameter int QW = 15,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [RW-1:0] in_rem,
  input  logic [QW-1:0] in_low,
  input  logic [RW-1:0] in_dvs,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic [QW-1:0] vld_r;
  logic [RW-1:0] rem_r  [QW];
  logic [RW-1:0] dvs_r  [QW];
  logic [QW-1:0] quo_r  [QW];
  logic [QW-1:0] low_r  [QW];
  logic [SW-1:0] side_r [QW];

  // One quotient bit per stage, restoring
  for (genvar s = 0; s < QW; s++) begin : g_stg
    logic          vld_i;
    logic [RW-1:0] rem_i;
    logic [RW-1:0] dvs_i;
    logic [QW-1:0] quo_i;
    logic [QW-1:0] low_i;
    logic [SW-1:0] side_i;
    logic [RW:0]   trial;
    logic [RW:0]   diff;
    logic          ge;

    if (s == 0) begin : g_first
      assign vld_i  = in_vld;
      assign rem_i  = in_rem;
      assign dvs_i  = in_dvs;
      assign quo_i  = '0;
      assign low_i  = in_low;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld_r[s-1];
      assign rem_i  = rem_r[s-1];
      assign dvs_i  = dvs_r[s-1];
      assign quo_i  = quo_r[s-1];
      assign low_i  = low_r[s-1];
      assign side_i = side_r[s-1];
    end

    assign trial = {rem_i, low_i[QW-1]};
    assign diff  = trial - {1'b0, dvs_i};
    assign ge    = (trial >= {1'b0, dvs_i});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s]  <= ge ? diff[RW-1:0] : trial[RW-1:0];
      dvs_r[s]  <= dvs_i;
      quo_r[s]  <= {quo_i[QW-2:0], ge};
      low_r[s]  <= {low_i[QW-2:0], 1'b0};
      side_r[s] <= side_i;
    end
  end

  assign out_vld  = vld_r[QW-1];
  assign out_quo  = quo_r[QW-1];
  assign out_side = side_r[QW-1];

endmodule

@@ hdl/wsfe_exp.sv @@
module wsfe_exp (
  input  logic        clk,
  input  logic [23:0] t,
  output logic [16:0] e
);
  import wsfe_pkg::*;

  logic [7:0]  k;
  logic [2:0]  idx;
  logic [12:0] fr;
  logic [16:0] hi;
  logic [16:0] lo;
  logic [16:0] dfull;
  logic [25:0] slope;
  logic [16:0] interp_nxt;
  logic [16:0] ival_nxt;
  logic [16:0] interp_r;
  logic [16:0] ival_r;
  logic [33:0] prod;
  logic [16:0] e_r;

  // Split into integer and eighth-step parts, interpolate the fraction
  assign k          = t[23:16];
  assign idx        = t[15:13];
  assign fr         = t[12:0];
  assign hi         = exp_frac_rom({1'b0, idx});
  assign lo         = exp_frac_rom({1'b0, idx} + 4'd1);
  assign dfull      = hi - lo;
  assign slope      = dfull[12:0] * fr;
  assign interp_nxt = hi - {4'b0, slope[25:13]};
  assign ival_nxt   = (k < 8'd12) ? exp_int_rom(k[3:0]) : 17'd0;

  always_ff @(posedge clk) begin
    ival_r   <= ival_nxt;
    interp_r <= interp_nxt;
  end

  // Combine the two parts, round half up
  assign prod = ival_r * interp_r + 34'd32768;

  always_ff @(posedge clk) begin
    e_r <= prod[32:16];
  end

  assign e = e_r;

endmodule

@@ hdl/wsfe_lane.sv @@
module wsfe_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [15:0] in_body,
  input  logic signed [15:0] in_rate,
  input  wsfe_pkg::cfg_t     cfg,
  output logic               out_vld,
  output logic [15:0]        out_slip,
  output logic [15:0]        out_mu
);
  import wsfe_pkg::*;

  // Rim speed product
  logic               a_vld_r;
  logic signed [32:0] a_prod_r;
  logic signed [15:0] a_body_r;
  logic signed [32:0] a_prod_nxt;

  assign a_prod_nxt = $signed({1'b0, cfg.radius}) * in_rate;

  always_ff @(posedge clk) begin
    a_prod_r <= a_prod_nxt;
    a_body_r <= in_body;
  end

  // Floor the rim speed, take the speed difference
  logic               b_vld_r;
  logic [15:0]        b_rem_r;
  logic [15:0]        b_rim_r;
  logic               b_sat_r;
  logic [15:0]        rim_raw;
  logic [15:0]        rim;
  logic signed [17:0] diff;
  logic signed [17:0] diff_abs;
  logic [15:0]        mag;
  logic               sat;

  assign rim_raw  = a_prod_r[31:16];
  assign rim      = (a_prod_r[32] || rim_raw == 16'd0) ? 16'd1 : rim_raw;
  assign diff     = $signed({2'b00, rim}) - $signed({{2{a_body_r[15]}}, a_body_r});
  assign diff_abs = diff[17] ? -diff : diff;
  assign mag      = diff_abs[15:0];
  assign sat      = (mag >= rim);

  always_ff @(posedge clk) begin
    b_rem_r <= sat ? 16'd0 : mag;
    b_rim_r <= rim;
    b_sat_r <= sat;
  end

  // Slip division
  logic        s_vld;
  logic [14:0] s_quo;
  logic [0:0]  s_side;

  wsfe_div #(.RW(16), .QW(15), .SW(1)) u_div_slip (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (b_vld_r),
    .in_rem  (b_rem_r),
    .in_low  (15'd0),
    .in_dvs  (b_rim_r),
    .in_side (b_sat_r),
    .out_vld (s_vld),
    .out_quo (s_quo),
    .out_side(s_side)
  );

  logic        c_vld_r;
  logic [15:0] c_slip_r;

  always_ff @(posedge clk) begin
    c_slip_r <= s_side[0] ? SLIP_ONE : {1'b0, s_quo};
  end

  // Normalise slip by the breakaway slip
  logic [15:0] bs;
  logic        usat;
  logic [15:0] u_rem0;
  logic [19:0] u_low;
  logic        u_vld;
  logic [19:0] u_quo;
  logic [16:0] u_side;

  assign bs     = (cfg.bslip == 16'd0) ? 16'd1 : cfg.bslip;
  assign usat   = ({4'b0, c_slip_r} >= {bs, 4'b0});
  assign u_rem0 = usat ? 16'd0 : {4'b0, c_slip_r[15:4]};
  assign u_low  = {c_slip_r[3:0], 16'd0};

  wsfe_div #(.RW(16), .QW(20), .SW(17)) u_div_u (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (c_vld_r),
    .in_rem  (u_rem0),
    .in_low  (u_low),
    .in_dvs  (bs),
    .in_side ({usat, c_slip_r}),
    .out_vld (u_vld),
    .out_quo (u_quo),
    .out_side(u_side)
  );

  // Clamp u at 8.0
  logic        e_vld_r;
  logic [19:0] e_u_r;
  logic [15:0] e_slip_r;

  always_ff @(posedge clk) begin
    e_u_r    <= (u_side[16] || u_quo > U_MAX) ? U_MAX : u_quo;
    e_slip_r <= u_side[15:0];
  end

  // Exponent arguments
  logic        f_vld_r;
  logic [23:0] f_t1_r;
  logic [23:0] f_t2_r;
  logic [19:0] f_u_r;
  logic [15:0] f_slip_r;
  logic [39:0] uu;

  assign uu = e_u_r * e_u_r;

  always_ff @(posedge clk) begin
    f_t1_r   <= {1'b0, uu[39:17]};
    f_t2_r   <= {e_u_r, 4'b0} + {2'b0, e_u_r, 2'b0};
    f_u_r    <= e_u_r;
    f_slip_r <= e_slip_r;
  end

  // Two exponent units, two stages each
  logic [16:0] e1;
  logic [16:0] e2;

  wsfe_exp u_exp_peak (.clk(clk), .t(f_t1_r), .e(e1));
  wsfe_exp u_exp_tanh (.clk(clk), .t(f_t2_r), .e(e2));

  logic        g_vld_r;
  logic [19:0] g_u_r;
  logic [15:0] g_slip_r;
  logic        h_vld_r;
  logic [19:0] h_u_r;
  logic [15:0] h_slip_r;

  always_ff @(posedge clk) begin
    g_u_r    <= f_u_r;
    g_slip_r <= f_slip_r;
    h_u_r    <= g_u_r;
    h_slip_r <= g_slip_r;
  end

  // Stribeck peak: u * exp(-u^2/2), then scale by e
  logic        i_vld_r;
  logic [19:0] i_p_r;
  logic [16:0] i_e2_r;
  logic [15:0] i_slip_r;
  logic [36:0] pm;

  assign pm = h_u_r * e1;

  always_ff @(posedge clk) begin
    i_p_r    <= pm[35:16];
    i_e2_r   <= e2;
    i_slip_r <= h_slip_r;
  end

  logic        j_vld_r;
  logic [20:0] j_q_r;
  logic [16:0] j_e2_r;
  logic [15:0] j_slip_r;
  logic [37:0] qm;

  assign qm = i_p_r * E_Q16;

  always_ff @(posedge clk) begin
    j_q_r    <= qm[36:16];
    j_e2_r   <= i_e2_r;
    j_slip_r <= i_slip_r;
  end

  // Stribeck term, signed by breakaway minus coulomb
  logic               k_vld_r;
  logic signed [21:0] k_term1_r;
  logic [16:0]        k_e2_r;
  logic [15:0]        k_slip_r;
  logic signed [16:0] dlev;
  logic signed [16:0] dlev_abs;
  logic [36:0]        t1m;
  logic signed [21:0] t1_mag;

  assign dlev     = $signed({1'b0, cfg.brk}) - $signed({1'b0, cfg.coul});
  assign dlev_abs = dlev[16] ? -dlev : dlev;
  assign t1m      = dlev_abs[15:0] * j_q_r;
  assign t1_mag   = $signed({1'b0, t1m[36:16]});

  always_ff @(posedge clk) begin
    k_term1_r <= dlev[16] ? -t1_mag : t1_mag;
    k_e2_r    <= j_e2_r;
    k_slip_r  <= j_slip_r;
  end

  // tanh as (1 - E) / (1 + E); with E at zero the ratio is exactly one
  logic [17:0] th_rem0;
  logic [17:0] th_dvs;
  logic        t_vld;
  logic [14:0] t_quo;
  logic [38:0] t_side;
  logic [15:0] t_th;

  assign th_rem0 = 18'd65536 - {1'b0, k_e2_r};
  assign th_dvs  = 18'd65536 + {1'b0, k_e2_r};

  wsfe_div #(.RW(18), .QW(15), .SW(39)) u_div_tanh (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (k_vld_r),
    .in_rem  (th_rem0),
    .in_low  (15'd0),
    .in_dvs  (th_dvs),
    .in_side ({k_e2_r == 17'd0, k_term1_r, k_slip_r}),
    .out_vld (t_vld),
    .out_quo (t_quo),
    .out_side(t_side)
  );

  assign t_th = t_side[38] ? 16'h8000 : {1'b0, t_quo};

  // Coulomb and viscous terms
  logic               l_vld_r;
  logic signed [21:0] l_term1_r;
  logic [15:0]        l_term2_r;
  logic signed [16:0] l_term3_r;
  logic [15:0]        l_slip_r;
  logic [30:0]        t2m;
  logic signed [16:0] visc_abs;
  logic [31:0]        t3m;
  logic signed [16:0] t3_mag;

  assign t2m      = cfg.coul * t_th;
  assign visc_abs = cfg.visc[15] ? -$signed({cfg.visc[15], cfg.visc})
                                 : $signed({cfg.visc[15], cfg.visc});
  assign t3m      = visc_abs[15:0] * t_side[15:0];
  assign t3_mag   = $signed({1'b0, t3m[30:15]});

  always_ff @(posedge clk) begin
    l_term1_r <= $signed(t_side[37:16]);
    l_term2_r <= t2m[30:15];
    l_term3_r <= cfg.visc[15] ? -t3_mag : t3_mag;
    l_slip_r  <= t_side[15:0];
  end

  // Sum, floor at min_mu, saturate
  logic               m_vld_r;
  logic [15:0]        m_mu_r;
  logic [15:0]        m_slip_r;
  logic signed [23:0] sum;
  logic [15:0]        mu_nxt;

  assign sum = {{2{l_term1_r[21]}}, l_term1_r} + $signed({8'b0, l_term2_r})
             + {{7{l_term3_r[16]}}, l_term3_r} + {{8{cfg.bias[15]}}, cfg.bias};

  always_comb begin
    if (sum < $signed({8'b0, cfg.min_mu})) begin
      mu_nxt = cfg.min_mu;
    end else if (sum > $signed(24'd65535)) begin
      mu_nxt = 16'hFFFF;
    end else begin
      mu_nxt = sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    m_mu_r   <= mu_nxt;
    m_slip_r <= l_slip_r;
  end

  // Valid chain around the dividers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
      g_vld_r <= 1'b0;
      h_vld_r <= 1'b0;
      i_vld_r <= 1'b0;
      j_vld_r <= 1'b0;
      k_vld_r <= 1'b0;
      l_vld_r <= 1'b0;
      m_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= s_vld;
      e_vld_r <= u_vld;
      f_vld_r <= e_vld_r;
      g_vld_r <= f_vld_r;
      h_vld_r <= g_vld_r;
      i_vld_r <= h_vld_r;
      j_vld_r <= i_vld_r;
      k_vld_r <= j_vld_r;
      l_vld_r <= t_vld;
      m_vld_r <= l_vld_r;
    end
  end

  assign out_vld  = m_vld_r;
  assign out_slip = m_slip_r;
  assign out_mu   = m_mu_r;

endmodule

@@ hdl/wheel_slip_friction_estimator.sv @@
// Wheel slip and friction estimator. Each start beat carries the body speed and
// four wheel rates; one result beat then gives slip and friction for every wheel
// on out_valid for a single cycle. A new beat is taken every cycle and busy
// stays low: each wheel has its own fully pipelined lane, most of whose depth is
// in its three one-bit-per-stage dividers (slip, normalised slip and tanh, 15, 20
// and 15 stages). There is no back-pressure on the result side, so the receiver
// must take every beat as it appears. The user must change registers only while
// no beat is in flight; the block does not enforce it. cfg_ready is always high.
module wheel_slip_friction_estimator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_body_speed,
  input  logic [15:0] in_wheel_rate_0,
  input  logic [15:0] in_wheel_rate_1,
  input  logic [15:0] in_wheel_rate_2,
  input  logic [15:0] in_wheel_rate_3,
  output logic        out_valid,
  output logic [15:0] out_slip_0,
  output logic [15:0] out_slip_1,
  output logic [15:0] out_slip_2,
  output logic [15:0] out_slip_3,
  output logic [15:0] out_mu_0,
  output logic [15:0] out_mu_1,
  output logic [15:0] out_mu_2,
  output logic [15:0] out_mu_3,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import wsfe_pkg::*;

  logic accept;
  cfg_t cfg_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radius <= 16'd9830;
      cfg_r.brk    <= 16'd26214;
      cfg_r.coul   <= 16'd16384;
      cfg_r.bslip  <= 16'd13107;
      cfg_r.visc   <= -16'sd328;
      cfg_r.bias   <= 16'sd0;
      cfg_r.min_mu <= 16'd33;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        REG_RADIUS: cfg_r.radius <= cfg_data;
        REG_BRK:    cfg_r.brk    <= cfg_data;
        REG_COUL:   cfg_r.coul   <= cfg_data;
        REG_BSLIP:  cfg_r.bslip  <= cfg_data;
        REG_VISC:   cfg_r.visc   <= $signed(cfg_data);
        REG_BIAS:   cfg_r.bias   <= $signed(cfg_data);
        REG_MIN_MU: cfg_r.min_mu <= cfg_data;
        default: ;
      endcase
    end
  end

  // One lane per wheel
  logic [15:0]            rate [WHEEL_COUNT];
  logic [WHEEL_COUNT-1:0] lane_vld;
  logic [15:0]            lane_slip [WHEEL_COUNT];
  logic [15:0]            lane_mu   [WHEEL_COUNT];

  assign rate[0] = in_wheel_rate_0;
  assign rate[1] = in_wheel_rate_1;
  assign rate[2] = in_wheel_rate_2;
  assign rate[3] = in_wheel_rate_3;

  for (genvar w = 0; w < WHEEL_COUNT; w++) begin : g_lane
    wsfe_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (accept),
      .in_body ($signed(in_body_speed)),
      .in_rate ($signed(rate[w])),
      .cfg     (cfg_r),
      .out_vld (lane_vld[w]),
      .out_slip(lane_slip[w]),
      .out_mu  (lane_mu[w])
    );
  end

  // Merge lane results into the output beat
  logic        out_valid_r;
  logic [15:0] slip_r [WHEEL_COUNT];
  logic [15:0] mu_r   [WHEEL_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= &lane_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int w = 0; w < WHEEL_COUNT; w++) begin
      slip_r[w] <= lane_slip[w];
      mu_r[w]   <= lane_mu[w];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_slip_0 = slip_r[0];
  assign out_slip_1 = slip_r[1];
  assign out_slip_2 = slip_r[2];
  assign out_slip_3 = slip_r[3];
  assign out_mu_0   = mu_r[0];
  assign out_mu_1   = mu_r[1];
  assign out_mu_2   = mu_r[2];
  assign out_mu_3   = mu_r[3];

  // Checks
  a_out_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, OUT_LAT))
    else $error("result beat without a start beat at the pipeline depth");

  a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    lane_vld == '0 || lane_vld == '1)
    else $error("wheel lanes out of step");

  a_slip_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_slip_0 <= SLIP_ONE && out_slip_1 <= SLIP_ONE &&
                   out_slip_2 <= SLIP_ONE && out_slip_3 <= SLIP_ONE))
    else $error("slip above one");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import wsfe_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef logic [3:0][15:0] quad_t;

  typedef struct {
    quad_t slip;
    quad_t mu;
  } friction_result_t;

  // Friction estimate predictor and queue of pending results
  class friction_scoreboard;
    cfg_t regs;
    friction_result_t pending_q[$];
    int fails;
    int seen;
    longint exp_int[12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1};
    longint exp_frac[9] = '{65536, 57835, 51039, 45042, 39750, 35079, 30957,
                            27319, 24109};

    function new();
      regs = '{radius: 16'd9830, brk: 16'd26214, coul: 16'd16384, bslip: 16'd13107,
               visc: -16'sd328, bias: 16'sd0, min_mu: 16'd33};
      fails = 0;
      seen = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_RADIUS: regs.radius = data;
        REG_BRK:    regs.brk = data;
        REG_COUL:   regs.coul = data;
        REG_BSLIP:  regs.bslip = data;
        REG_VISC:   regs.visc = data;
        REG_BIAS:   regs.bias = data;
        REG_MIN_MU: regs.min_mu = data;
        default: ;
      endcase
    endfunction

    // exp(-t), t and result in Q.16
    function longint exp_neg(longint t);
      longint k, f, idx, rem, hi, lo, interp;
      k = t >>> 16;
      if (k >= 12) return 0;
      f = t & 16'hFFFF;
      idx = f >>> 13;
      rem = f & 13'h1FFF;
      hi = exp_frac[idx];
      lo = exp_frac[idx + 1];
      interp = hi - (((hi - lo) * rem) >>> 13);
      return (exp_int[k] * interp + 32768) >>> 16;
    endfunction

    // signed times unsigned, shifted with truncation toward zero
    function longint mul_trunc(longint a, longint b, int sh);
      longint m;
      m = ((a < 0 ? -a : a) * b) >>> sh;
      return a < 0 ? -m : m;
    endfunction

    function longint wheel_slip(longint body, longint rate);
      longint prod, rim, mag, num;
      prod = longint'(regs.radius) * rate;
      if (prod < 0) rim = -(((-prod) + 65535) >>> 16);
      else rim = prod >>> 16;
      if (rim < 1) rim = 1;
      mag = rim - body;
      if (mag < 0) mag = -mag;
      num = mag << 15;
      if (num >= rim * 32768) return 32768;
      return num / rim;
    endfunction

    function longint wheel_mu(longint slip);
      longint bs, u, t1, p, q, e2, th, term1, term2, term3, sum;
      bs = (regs.bslip == 0) ? 1 : longint'(regs.bslip);
      u = (slip << 16) / bs;
      if (u > 524288) u = 524288;
      t1 = (u * u) >>> 17;
      p = (u * exp_neg(t1)) >>> 16;
      q = (p * 178145) >>> 16;
      term1 = mul_trunc(longint'(regs.brk) - longint'(regs.coul), q, 16);
      e2 = exp_neg(20 * u);
      th = ((65536 - e2) << 15) / (65536 + e2);
      term2 = (longint'(regs.coul) * th) >>> 15;
      term3 = mul_trunc(longint'(regs.visc), slip, 15);
      sum = term1 + term2 + term3 + longint'(regs.bias);
      if (sum < longint'(regs.min_mu)) sum = regs.min_mu;
      if (sum > 65535) sum = 65535;
      return sum;
    endfunction

    // Note an accepted input beat
    function void note_input(logic signed [15:0] body, quad_t rates);
      friction_result_t r;
      longint s;
      longint m;
      for (int w = 0; w < 4; w++) begin
        s = wheel_slip(longint'(body), longint'($signed(rates[w])));
        m = wheel_mu(s);
        r.slip[w] = s[15:0];
        r.mu[w] = m[15:0];
      end
      pending_q.push_back(r);
    endfunction

    // Compare a result beat with the oldest expectation
    function void check_result(quad_t slip, quad_t mu);
      friction_result_t e;
      seen++;
      if (pending_q.size() == 0) begin
        $error("result beat with nothing expected");
        fails++;
        return;
      end
      e = pending_q.pop_front();
      for (int w = 0; w < 4; w++) begin
        if (slip[w] !== e.slip[w]) begin
          $error("slip_%0d: expected %0d, got %0d", w, e.slip[w], slip[w]);
          fails++;
        end
        if (mu[w] !== e.mu[w]) begin
          $error("mu_%0d: expected %0d, got %0d", w, e.mu[w], mu[w]);
          fails++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [15:0] in_body_speed = '0;
  quad_t in_rates = '0;
  logic out_valid;
  quad_t out_slip, out_mu;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  friction_scoreboard sb;
  int cycles = 0;
  int items = 0;
  int phases = 0;
  bit no_idle = 1'b0;

  wheel_slip_friction_estimator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_body_speed(in_body_speed),
    .in_wheel_rate_0(in_rates[0]), .in_wheel_rate_1(in_rates[1]),
    .in_wheel_rate_2(in_rates[2]), .in_wheel_rate_3(in_rates[3]),
    .out_valid(out_valid),
    .out_slip_0(out_slip[0]), .out_slip_1(out_slip[1]),
    .out_slip_2(out_slip[2]), .out_slip_3(out_slip[3]),
    .out_mu_0(out_mu[0]), .out_mu_1(out_mu[1]),
    .out_mu_2(out_mu[2]), .out_mu_3(out_mu[3]),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("wheel_slip_friction_estimator test failed");
      $finish;
    end
  end

  // Take every result beat
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_slip, out_mu);
  end

  // Drop start for a random burst now and then
  task automatic maybe_idle();
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk);
    end
  endtask

  // Present one input beat and hold it until taken
  task automatic send_item(logic [15:0] body, quad_t rates);
    maybe_idle();
    @(negedge clk);
    start = 1'b1;
    in_body_speed = body;
    in_rates = rates;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_input(body, rates);
    items++;
  endtask

  // Stop sending and wait for the pipeline to empty
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (OUT_LAT + 8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic load_regs(logic [6:0][15:0] v);
    for (int i = 0; i < 7; i++) write_reg(i[2:0], v[i]);
    write_reg(REG_UNUSED, 16'($urandom));
    @(negedge clk);
    cfg_valid = 1'b0;
    phases++;
  endtask

  // Random beat: mostly wheels near the body speed so slip lands on the curve
  task automatic send_random();
    logic [15:0] body;
    quad_t rates;
    longint b, r, nom;
    b = longint'($signed(16'($urandom)));
    if ($urandom_range(0, 1)) b = b / longint'($urandom_range(1, 64));
    body = b[15:0];
    for (int w = 0; w < 4; w++) begin
      if ($urandom_range(0, 4) == 0 || sb.regs.radius == 0) begin
        rates[w] = 16'($urandom);
      end else begin
        nom = (b * 65536) / longint'(sb.regs.radius);
        r = nom + nom / longint'($urandom_range(2, 40)) * ($urandom_range(0, 1) ? 1 : -1)
            + $signed($urandom_range(0, 8)) - 4;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        rates[w] = r[15:0];
      end
    end
    send_item(body, rates);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2 && phases == 4) begin
        // hold off until every result is back
        @(negedge clk);
        start = 1'b0;
        while (sb.pending_q.size() != 0) @(posedge clk);
      end
      send_random();
    end
    drain();
  endtask

  function automatic logic [6:0][15:0] random_regs();
    logic [6:0][15:0] v;
    v[0] = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(2000, 20000));
    v[1] = 16'($urandom);
    v[2] = 16'($urandom);
    v[3] = $urandom_range(0, 3) ? 16'($urandom_range(1, 32768)) : 16'($urandom);
    v[4] = 16'($urandom);
    v[5] = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 4000));
    v[6] = 16'($urandom_range(0, 3) ? $urandom_range(0, 2000) : $urandom);
    return v;
  endfunction

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed beats on reset settings: extremes, stopped and reverse wheels
    send_item(16'h0000, '{16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send_item(16'h7FFF, '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001});
    send_item(16'h8000, '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF});
    send_item(16'h0100, '{16'h0683, 16'h06A0, 16'h0700, 16'h0800});
    send_item(16'h0100, '{16'h0640, 16'h0600, 16'h0500, 16'h0300});
    send_item(16'h0A00, '{16'h4120, 16'h4200, 16'h4000, 16'h3E00});
    send_item(16'hFF00, '{16'hF980, 16'h0680, 16'h0007, 16'h0006});
    send_item(16'h0001, '{16'h0007, 16'h0008, 16'h000E, 16'h0014});
    send_item(16'h5555, '{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
    send_item(16'hAAAA, '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
    drain();
    random_phase(80);

    // Extremes of the registers, zero breakaway slip among them
    load_regs('{16'd33, 16'h7FFF, 16'h7FFF, 16'd32768, 16'd0, 16'hFFFF, 16'hFFFF});
    send_item(16'h0100, '{16'h0101, 16'h0200, 16'h8000, 16'h7FFF});
    random_phase(30);
    load_regs('{16'd0, 16'h8000, 16'h8000, 16'd0, 16'hFFFF, 16'd0, 16'd0});
    send_item(16'h0100, '{16'h0101, 16'h0200, 16'h8000, 16'h7FFF});
    random_phase(30);
    load_regs('{16'd0, 16'h7FFF, 16'h0001, 16'd1, 16'd0, 16'h0000, 16'h4000});
    random_phase(30);

    for (int p = 0; p < 4; p++) begin
      load_regs(random_regs());
      random_phase(50);
    end

    // Back to the reset values, last stretch without idling
    load_regs('{16'd33, 16'd0, 16'hFEB8, 16'd13107, 16'd16384, 16'd26214, 16'd9830});
    random_phase(40);
    no_idle = 1'b1;
    random_phase(40);

    $display("covered %0d input beats and %0d result beats over %0d register settings",
             items, sb.seen, phases + 1);
    if (sb.fails == 0 && sb.pending_q.size() == 0) begin
      $display("wheel_slip_friction_estimator test passed");
    end else begin
      $display("wheel_slip_friction_estimator test failed");
    end
    $finish;
  end
endmodule
